// ----- rtl/pointwise_conv_accumulator_top_assert.svh -----
// assertion macros for the pointwise convolution accumulator
`ifndef POINTWISE_CONV_ACCUMULATOR_TOP_ASSERT_SVH
`define POINTWISE_CONV_ACCUMULATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PCA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pca assertion failed");
`define PCA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pca forbidden condition seen");
`else
`define PCA_ASSERT(lbl, prop)
`define PCA_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/pca_pkg.sv -----
package pca_pkg;

  localparam int OPCODE_W   = 2;
  localparam int FILTER_W   = 4;
  localparam int DEPTH_W    = 10;
  localparam int PIXEL_W    = 6;
  localparam int DATA_W     = 8;
  localparam int PROD_W     = 16;
  localparam int SUM_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int CONV_DEPTH_W = 11;
  localparam int VALID_FILT_W = 5;

  localparam logic [OPCODE_W-1:0] OP_WEIGHT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ACCUM  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CONV_DEPTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_FILTERS = 1'd1;

  localparam logic [CONV_DEPTH_W-1:0] CONV_DEPTH_RST    = 11'd1024;
  localparam logic [VALID_FILT_W-1:0] VALID_FILTERS_RST = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WGT_WR,
    ST_ACC_RD,
    ST_ACC_MUL,
    ST_ACC_WR,
    ST_SUM_RD,
    ST_SUM_WAIT
  } pca_state_e;

  typedef struct packed {
    logic item_load;
    logic wgt_we;
    logic acc_rd;
    logic acc_mul;
    logic acc_wr;
    logic sum_rd;
    logic out_load;
  } pca_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                pix_ok;
    logic                cnt_last;
    logic                out_free;
  } pca_stat_t;

endpackage

// ----- rtl/pca_in_if.sv -----
interface pca_in_if;
  import pca_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [FILTER_W-1:0]        filter_index;
  logic [DEPTH_W-1:0]         depth_index;
  logic [PIXEL_W-1:0]         pixel_index;
  logic signed [DATA_W-1:0]   data_value;

  modport source (
    output valid, opcode, filter_index, depth_index, pixel_index, data_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, filter_index, depth_index, pixel_index, data_value,
    output ready
  );
endinterface

// ----- rtl/pca_out_if.sv -----
interface pca_out_if;
  import pca_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SUM_W-1:0]  partial_sum;
  logic [FILTER_W-1:0]      echo_filter;
  logic [PIXEL_W-1:0]       echo_pixel;

  modport source (
    output valid, partial_sum, echo_filter, echo_pixel,
    input  ready
  );
  modport sink (
    input  valid, partial_sum, echo_filter, echo_pixel,
    output ready
  );
endinterface

// ----- rtl/pca_ctrl.sv -----
`include "pointwise_conv_accumulator_top_assert.svh"

module pca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pca_pkg::pca_stat_t stat_i,
  output pca_pkg::pca_cmd_t  cmd_o
);
  import pca_pkg::*;

  pca_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.opcode)
          OP_WEIGHT: state_d = ST_WGT_WR;
          OP_ACCUM:  state_d = stat_i.pix_ok ? ST_ACC_RD : ST_IDLE;
          OP_READ:   state_d = ST_SUM_RD;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_WGT_WR: begin
        cmd_o.wgt_we = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_ACC_RD: begin
        cmd_o.acc_rd = 1'b1;
        state_d      = ST_ACC_MUL;
      end
      ST_ACC_MUL: begin
        cmd_o.acc_mul = 1'b1;
        state_d       = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd_o.acc_wr = 1'b1;
        state_d      = stat_i.cnt_last ? ST_IDLE : ST_ACC_RD;
      end
      ST_SUM_RD: begin
        cmd_o.sum_rd = 1'b1;
        state_d      = ST_SUM_WAIT;
      end
      ST_SUM_WAIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `PCA_ASSERT(a_one_cmd, $onehot0(cmd_o))
  `PCA_ASSERT(a_load_decode, cmd_o.item_load |=> state_q == ST_DECODE)
  `PCA_ASSERT(a_last_idle, cmd_o.acc_wr && stat_i.cnt_last |=> state_q == ST_IDLE)
  `PCA_ASSERT(a_rd_then_mul, cmd_o.acc_rd |=> cmd_o.acc_mul)
  `PCA_ASSERT_NEVER(a_out_blocked, cmd_o.out_load && !stat_i.out_free)

endmodule

// ----- rtl/pca_datapath.sv -----
module pca_datapath #(
  parameter int FILTERS_PER_BLOCK = 16,
  parameter int MAX_DEPTH         = 1024,
  parameter int TILE_PIXELS       = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pca_pkg::pca_cmd_t                 cmd_i,
  output pca_pkg::pca_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic [pca_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pca_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [pca_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [pca_pkg::FILTER_W-1:0]      filter_index_i,
  input  logic [pca_pkg::DEPTH_W-1:0]       depth_index_i,
  input  logic [pca_pkg::PIXEL_W-1:0]       pixel_index_i,
  input  logic signed [pca_pkg::DATA_W-1:0] data_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pca_pkg::SUM_W-1:0]  partial_sum_o,
  output logic [pca_pkg::FILTER_W-1:0]      echo_filter_o,
  output logic [pca_pkg::PIXEL_W-1:0]       echo_pixel_o
);
  import pca_pkg::*;

  localparam int WGT_DEPTH = FILTERS_PER_BLOCK * MAX_DEPTH;
  localparam int SUM_DEPTH = FILTERS_PER_BLOCK * TILE_PIXELS;
  localparam int WA_W = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int SA_W = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int FW   = (FILTERS_PER_BLOCK > 1) ? $clog2(FILTERS_PER_BLOCK) : 1;

  logic signed [DATA_W-1:0] wmem [WGT_DEPTH];
  logic signed [SUM_W-1:0]  smem [SUM_DEPTH];

  logic [OPCODE_W-1:0]      op_q;
  logic [FILTER_W-1:0]      fil_q;
  logic [DEPTH_W-1:0]       dep_q;
  logic [PIXEL_W-1:0]       pix_q;
  logic signed [DATA_W-1:0] val_q;

  logic [CONV_DEPTH_W-1:0]  conv_depth_q;
  logic [VALID_FILT_W-1:0]  valid_filters_q;

  logic [FW-1:0]            cnt_q, cnt_d;
  logic signed [DATA_W-1:0] wgt_rd_q;
  logic signed [SUM_W-1:0]  sum_rd_q;
  logic signed [PROD_W-1:0] prod_q, mul;
  logic signed [SUM_W-1:0]  base_q;
  logic                     out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0]  psum_q;
  logic [FILTER_W-1:0]      efil_q;
  logic [PIXEL_W-1:0]       epix_q;

  logic [WA_W-1:0] wgt_waddr, wgt_raddr;
  logic [SA_W-1:0] sum_waddr, sum_raddr;
  logic [31:0]     fil_sel;
  logic            wgt_ok, pix_ok, fil_ok, contrib;

  // item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q  <= opcode_i;
      fil_q <= filter_index_i;
      dep_q <= depth_index_i;
      pix_q <= pixel_index_i;
      val_q <= data_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_depth_q    <= CONV_DEPTH_RST;
      valid_filters_q <= VALID_FILTERS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CONV_DEPTH:    conv_depth_q    <= cfg_data_i;
        CFG_VALID_FILTERS: valid_filters_q <= cfg_data_i[VALID_FILT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix_ok  = 32'(pix_q) < 32'(TILE_PIXELS);
  assign fil_ok  = 32'(fil_q) < 32'(FILTERS_PER_BLOCK);
  assign wgt_ok  = fil_ok && (32'(dep_q) < 32'(MAX_DEPTH));
  assign contrib = (32'(dep_q) < 32'(MAX_DEPTH)) && (32'(dep_q) < 32'(conv_depth_q))
                   && (32'(cnt_q) < 32'(valid_filters_q));

  assign wgt_waddr = WA_W'(32'(fil_q) * 32'(MAX_DEPTH) + 32'(dep_q));
  assign wgt_raddr = WA_W'(32'(cnt_q) * 32'(MAX_DEPTH) + 32'(dep_q));
  assign fil_sel   = cmd_i.acc_rd ? 32'(cnt_q) : 32'(fil_q);
  assign sum_raddr = SA_W'(fil_sel * 32'(TILE_PIXELS) + 32'(pix_q));
  assign sum_waddr = SA_W'(32'(cnt_q) * 32'(TILE_PIXELS) + 32'(pix_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wgt_we && wgt_ok) begin
      wmem[wgt_waddr] <= val_q;
    end
    if (cmd_i.acc_rd) begin
      wgt_rd_q <= wmem[wgt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_wr) begin
      smem[sum_waddr] <= base_q + SUM_W'(prod_q);
    end
    if (cmd_i.acc_rd || cmd_i.sum_rd) begin
      sum_rd_q <= smem[sum_raddr];
    end
  end

  assign mul = val_q * wgt_rd_q;

  // depth zero restarts the sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_mul) begin
      prod_q <= contrib ? mul : '0;
      base_q <= (dep_q == '0) ? '0 : sum_rd_q;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.item_load) begin
      cnt_d = '0;
    end else if (cmd_i.acc_wr) begin
      cnt_d = cnt_q + FW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      psum_q <= (fil_ok && pix_ok) ? sum_rd_q : '0;
      efil_q <= fil_q;
      epix_q <= pix_q;
    end
  end

  assign stat_o.opcode   = op_q;
  assign stat_o.pix_ok   = pix_ok;
  assign stat_o.cnt_last = cnt_q == FW'(FILTERS_PER_BLOCK - 1);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign partial_sum_o = psum_q;
  assign echo_filter_o = efil_q;
  assign echo_pixel_o  = epix_q;

endmodule

// ----- rtl/pointwise_conv_accumulator_top.sv -----
// pointwise (1x1) convolution multiply-accumulate engine
// in_ch takes one request at a time: opcode 0 stores a signed weight for a
// filter and depth, opcode 1 adds activation times weight into every
// filter's 32-bit sum for a pixel (depth 0 restarts the sums), opcode 2
// reads back one sum, opcode 3 is dropped
// out_ch returns one item per read request: sum, filter and pixel echoed
// a weight write passes the decode and write states, a read the decode,
// sum read and sum wait states, an accumulate the decode state and then
// walks the filters one by one through the weight and sum memories:
// read, multiply, write back
// cfg port: cfg_we_i with cfg_index_i 0 sets conv_depth, 1 sets
// valid_filters; write only while idle
// reset sets conv_depth to 1024 and valid_filters to 16, clears the
// controller and the output register; weight and sum memories hold
// garbage until written
// a stalled receiver holds the result in the output register; the next
// request is still taken, and only a second read waits for the slot
module pointwise_conv_accumulator_top #(
  parameter int FILTERS_PER_BLOCK = 16,
  parameter int MAX_DEPTH         = 1024,
  parameter int TILE_PIXELS       = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pca_in_if.sink                         in_ch,
  pca_out_if.source                      out_ch
);
  import pca_pkg::*;

  pca_cmd_t  cmd;
  pca_stat_t stat;

  pca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pca_datapath #(
    .FILTERS_PER_BLOCK (FILTERS_PER_BLOCK),
    .MAX_DEPTH         (MAX_DEPTH),
    .TILE_PIXELS       (TILE_PIXELS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (in_ch.opcode),
    .filter_index_i (in_ch.filter_index),
    .depth_index_i  (in_ch.depth_index),
    .pixel_index_i  (in_ch.pixel_index),
    .data_value_i   (in_ch.data_value),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .partial_sum_o  (out_ch.partial_sum),
    .echo_filter_o  (out_ch.echo_filter),
    .echo_pixel_o   (out_ch.echo_pixel)
  );

endmodule
